// ----- sv/gtos_pkg.sv -----
// Shared types, constants and the character-to-row lookup of the glyph text streamer.
package gtos_pkg;

   localparam int GLYPH_ROWS  = 128;
   localparam int GLYPH_BYTES = 16;
   localparam int STORE_DEPTH = GLYPH_ROWS * GLYPH_BYTES;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Rows in use run from 0 to 72.
   localparam int ROW_W  = 7;
   localparam int IDX_W  = $clog2(GLYPH_BYTES);
   localparam int STEP_W = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_RENDER = 1'b1;

   localparam logic [ROW_W-1:0] ROW_COLON = ROW_W'(10);

   localparam logic [7:0] CMD_COL_LO  = 8'h00;
   localparam logic [7:0] CMD_COL_HI  = 8'h10;
   localparam logic [7:0] CMD_PAGE    = 8'hB0;
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;
   localparam logic [7:0] BORDER_TOP  = 8'h01;
   localparam logic [7:0] BORDER_BOT  = 8'h80;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef enum logic [1:0] {
      POS_COL_LO,
      POS_COL_HI,
      POS_PAGE
   } pos_type;

   typedef struct packed {
      logic             hit;
      logic [ROW_W-1:0] row;
   } row_hit_type;

   // One classified job as it waits between the front and the back.
   typedef struct packed {
      logic             is_render;
      logic [10:0]      addr;
      logic [7:0]       data;
      logic [ROW_W-1:0] row;
      logic             blank;
      logic             narrow;
      logic             border;
      logic [7:0]       col;
      logic [2:0]       page;
   } item_type;

   function automatic row_hit_type lookup_row(input logic [7:0] ch);
      row_hit_type r;
      r.hit = 1'b1;
      r.row = '0;
      if (ch inside {[8'h30:8'h39]}) begin
         r.row = ROW_W'(ch - 8'h30);
      end else if (ch inside {[8'h61:8'h7A]}) begin
         r.row = ROW_W'(ch - 8'h61 + 8'd12);
      end else if (ch inside {[8'h41:8'h5A]}) begin
         r.row = ROW_W'(ch - 8'h41 + 8'd38);
      end else begin
         case (ch)
            8'h3A:   r.row = ROW_COLON;
            8'h2F:   r.row = ROW_W'(11);
            8'h21:   r.row = ROW_W'(64);
            8'h40:   r.row = ROW_W'(65);
            8'h23:   r.row = ROW_W'(66);
            8'h24:   r.row = ROW_W'(67);
            8'h25:   r.row = ROW_W'(68);
            8'h5E:   r.row = ROW_W'(69);
            8'h2B:   r.row = ROW_W'(70);
            8'h2D:   r.row = ROW_W'(71);
            8'h2E:   r.row = ROW_W'(72);
            default: r.hit = 1'b0;
         endcase
      end
      return r;
   endfunction

endpackage

// ----- sv/glyph_text_to_oled_stream.sv -----
// Top level of the 8x16 glyph text streamer for a page-addressed display controller.
// With the block idle, a render passes the job queue, the sequencer job register, the
// slot stage and the result register; a load is written to glyph memory as the idle
// sequencer takes it. One result byte per cycle unless the result port stalls, bounded
// by the single glyph memory read port; 22 bytes per render, 14 for colon or unknown.
// Reset clears the column cursor, the job queue and the sequencer; glyph memory is kept.
module glyph_text_to_oled_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [10:0] req_glyph_addr,
   input  logic [7:0]  req_glyph_byte,
   input  logic [7:0]  req_character,
   input  logic        req_border,
   input  logic        req_restart,
   input  logic [7:0]  req_start_column,
   input  logic [2:0]  req_page,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_command,
   output logic        rsp_last
);
   import gtos_pkg::*;

   // The front end classifies each request transfer and resolves the column of a
   // render at the moment it is accepted, so the cursor never waits on the back end.
   logic     push_valid;
   item_type push_item;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   item_type q_item;

   gtos_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_glyph_addr   (req_glyph_addr),
      .req_glyph_byte   (req_glyph_byte),
      .req_character    (req_character),
      .req_border       (req_border),
      .req_restart      (req_restart),
      .req_start_column (req_start_column),
      .req_page         (req_page),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_item        (push_item)
   );

   // Loads and renders share one queue so that they reach glyph memory in order.
   gtos_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_item)
   );

   // The back end walks each render through its position commands and glyph bytes,
   // reading memory in the slot stage, ahead of the result register.
   gtos_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_command (rsp_is_command),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   // A run always ends on a data byte, never on a position command.
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_command |-> !rsp_last)
      else $error("position command marked as last byte");

   // Every command byte is a column-low, column-high or page command.
   a_cmd_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_command |->
         (rsp_out_byte[7:4] == 4'h0 || rsp_out_byte[7:4] == 4'h1 ||
          rsp_out_byte[7:4] == 4'hB))
      else $error("command byte with an unknown opcode");

   // Nothing is offered on the result port right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

// ----- sv/gtos_front.sv -----
// Front end: accepts requests, maps characters to glyph rows and keeps the column cursor.
module gtos_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [10:0]          req_glyph_addr,
   input  logic [7:0]           req_glyph_byte,
   input  logic [7:0]           req_character,
   input  logic                 req_border,
   input  logic                 req_restart,
   input  logic [7:0]           req_start_column,
   input  logic [2:0]           req_page,
   input  logic                 q_full,
   output logic                 push_valid,
   output gtos_pkg::item_type   push_item
);
   import gtos_pkg::*;

   logic [7:0]  cursor_ff;
   logic [7:0]  cursor_in;
   logic [7:0]  col;
   row_hit_type hit;
   logic        narrow;
   logic        accepted;

   assign req_stall  = q_full;
   assign push_valid = req_valid;
   assign accepted   = req_valid && !q_full;

   always_comb begin
      hit    = lookup_row(req_character);
      narrow = !hit.hit || (hit.row == ROW_COLON);
      col    = req_restart ? req_start_column : cursor_ff;

      push_item.is_render = (req_type == REQ_RENDER);
      push_item.addr      = req_glyph_addr;
      push_item.data      = req_glyph_byte;
      push_item.row       = hit.row;
      push_item.blank     = !hit.hit;
      push_item.narrow    = narrow;
      push_item.border    = req_border;
      push_item.col       = col;
      push_item.page      = req_page;

      cursor_in = cursor_ff;
      if (accepted && (req_type == REQ_RENDER)) begin
         cursor_in = col + (narrow ? 8'd4 : 8'd8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
      end
   end

endmodule

// ----- sv/gtos_queue.sv -----
// Short job queue between the front end and the byte sequencer.
module gtos_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  gtos_pkg::item_type   push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output gtos_pkg::item_type   pop_item
);
   import gtos_pkg::*;

   item_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                push;
   logic                take;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entries_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign take      = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = take ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/gtos_back.sv -----
// Back end: glyph memory, byte sequencer and the registered result stage.
module gtos_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  gtos_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_is_command,
   output logic                 rsp_last
);
   import gtos_pkg::*;

   typedef struct packed {
      logic       is_cmd;
      logic [7:0] cmd_byte;
      logic       lower;
      logic       blank;
      logic       border;
      logic       last;
   } slot_type;

   logic [7:0]          store [STORE_DEPTH];
   logic [7:0]          rd_data_ff;

   seq_state_type       state_ff;
   seq_state_type       state_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   item_type            job_ff;
   item_type            job_in;

   logic                p1_valid_ff;
   logic                p1_valid_in;
   slot_type            p1_ff;
   slot_type            p1_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [7:0]          rsp_byte_ff;
   logic [7:0]          rsp_byte_in;
   logic                rsp_cmd_ff;
   logic                rsp_cmd_in;
   logic                rsp_last_ff;
   logic                rsp_last_in;

   logic                out_free;
   logic                p1_free;
   logic                issue;
   logic                mem_we;
   logic [STORE_AW-1:0] wr_addr;
   logic [STORE_AW-1:0] rd_addr;

   logic [STEP_W-1:0]   half;
   logic [STEP_W-1:0]   data1_end;
   logic [STEP_W-1:0]   tri2_end;
   logic [STEP_W-1:0]   last_step;
   logic [STEP_W-1:0]   idx;
   logic [3:0]          pg;
   pos_type             pos;
   logic [7:0]          data_byte;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign p1_free  = !p1_valid_ff || out_free;
   assign issue    = (state_ff == SEQ_RUN) && p1_free;
   assign wr_addr  = STORE_AW'(q_item.addr);
   assign rd_addr  = STORE_AW'({job_ff.row, idx[IDX_W-1:0]});

   // Decode of the current step into a command byte or a data read.
   always_comb begin
      half      = job_ff.narrow ? STEP_W'(4) : STEP_W'(8);
      data1_end = STEP_W'(3) + half;
      tri2_end  = STEP_W'(6) + half;
      last_step = STEP_W'(5) + half + half;
      idx       = '0;
      pg        = {1'b0, job_ff.page};
      pos       = POS_COL_LO;
      p1_in.is_cmd = 1'b0;
      p1_in.lower  = 1'b0;
      if (step_ff < STEP_W'(3)) begin
         p1_in.is_cmd = 1'b1;
         pos          = pos_type'(step_ff[1:0]);
      end else if (step_ff < data1_end) begin
         idx = step_ff - STEP_W'(3);
      end else if (step_ff < tri2_end) begin
         p1_in.is_cmd = 1'b1;
         pos          = pos_type'(2'(step_ff - data1_end));
         pg           = {1'b0, job_ff.page} + 4'd1;
      end else begin
         idx         = step_ff - STEP_W'(6);
         p1_in.lower = 1'b1;
      end
      case (pos)
         POS_COL_LO: p1_in.cmd_byte = CMD_COL_LO | (job_ff.col & NIBBLE_MASK);
         POS_COL_HI: p1_in.cmd_byte = CMD_COL_HI | {4'h0, job_ff.col[7:4]};
         POS_PAGE:   p1_in.cmd_byte = CMD_PAGE | {4'h0, pg};
         default:    p1_in.cmd_byte = CMD_COL_LO;
      endcase
      p1_in.blank  = job_ff.blank;
      p1_in.border = job_ff.border;
      p1_in.last   = (step_ff == last_step);
   end

   // Sequencer: loads in idle are written straight to memory, renders run step by step.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      job_in   = job_ff;
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.is_render) begin
                  job_in   = q_item;
                  step_in  = '0;
                  state_in = SEQ_RUN;
               end else begin
                  mem_we = (32'(q_item.addr) < STORE_DEPTH);
               end
            end
         end
         SEQ_RUN: begin
            if (issue) begin
               step_in = step_ff + 1'b1;
               if (step_ff == last_step) begin
                  if (q_valid && q_item.is_render) begin
                     q_pop   = 1'b1;
                     job_in  = q_item;
                     step_in = '0;
                  end else begin
                     state_in = SEQ_IDLE;
                  end
               end
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      job_ff  <= job_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[wr_addr] <= q_item.data;
      end
      if (issue) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // Slot stage and result register.
   always_comb begin
      p1_valid_in = p1_free ? issue : p1_valid_ff;
      data_byte   = p1_ff.blank ? 8'h00 : rd_data_ff;
      if (p1_ff.border) begin
         data_byte = data_byte | (p1_ff.lower ? BORDER_BOT : BORDER_TOP);
      end
      rsp_valid_in = out_free ? p1_valid_ff : rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free && p1_valid_ff) begin
         rsp_byte_in = p1_ff.is_cmd ? p1_ff.cmd_byte : data_byte;
         rsp_cmd_in  = p1_ff.is_cmd;
         rsp_last_in = p1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p1_ff <= p1_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_is_command = rsp_cmd_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
